@@ design/dtte_pkg.sv @@
// Shared types, codes and defaults for the transition table engine.
`default_nettype none

package dtte_pkg;

   // default sizing
   localparam int NUM_STATES_DEF      = 64;
   localparam int SLOTS_PER_STATE_DEF = 4;
   localparam int QUEUE_DEPTH         = 2;

   // fixed field widths
   localparam int ACT_W = 3;
   localparam int ST_W  = 6;
   localparam int SYM_W = 8;
   localparam int STS_W = 2;

   // action codes on the request channel
   localparam logic [ACT_W-1:0] ACT_ADD    = 3'd0;
   localparam logic [ACT_W-1:0] ACT_QUERY  = 3'd1;
   localparam logic [ACT_W-1:0] ACT_REMOVE = 3'd2;
   localparam logic [ACT_W-1:0] ACT_START  = 3'd3;
   localparam logic [ACT_W-1:0] ACT_FEED   = 3'd4;

   // status codes on the response channel
   localparam logic [STS_W-1:0] STATUS_OK   = 2'd0;
   localparam logic [STS_W-1:0] STATUS_FULL = 2'd1;
   localparam logic [STS_W-1:0] STATUS_NONE = 2'd2;

   typedef enum logic [2:0] {
      OP_ADD,
      OP_QUERY,
      OP_REMOVE,
      OP_START,
      OP_FEED,
      OP_NOP
   } op_type;

   typedef enum logic [1:0] {
      BK_SWEEP,
      BK_IDLE,
      BK_EXEC
   } back_state_type;

   typedef struct packed {
      logic [ACT_W-1:0] action;
      logic [ST_W-1:0]  from_state;
      logic [SYM_W-1:0] symbol;
      logic [ST_W-1:0]  to_state;
   } req_type;

   typedef struct packed {
      logic [STS_W-1:0] status;
      logic [ST_W-1:0]  target_state;
      logic             run_alive;
   } rsp_type;

   // classified item held in the queue
   typedef struct packed {
      op_type           op;
      logic             in_range;
      logic [ST_W-1:0]  from_state;
      logic [SYM_W-1:0] symbol;
      logic [ST_W-1:0]  to_state;
   } item_type;

endpackage

`default_nettype wire

@@ design/dtte_front.sv @@
// Front end: decodes the action and range-checks the row of each request item.
`default_nettype none

module dtte_front
   import dtte_pkg::*;
#(
   parameter int NUM_STATES = NUM_STATES_DEF
) (
   input  req_type  req_data,
   output item_type item
);

   // action decode, undefined codes become no-ops
   always_comb begin
      item.from_state = req_data.from_state;
      item.symbol     = req_data.symbol;
      item.to_state   = req_data.to_state;
      item.in_range   = (32'(req_data.from_state) < NUM_STATES);
      unique case (req_data.action)
         ACT_ADD:    item.op = OP_ADD;
         ACT_QUERY:  item.op = OP_QUERY;
         ACT_REMOVE: item.op = OP_REMOVE;
         ACT_START:  item.op = OP_START;
         ACT_FEED:   item.op = OP_FEED;
         default:    item.op = OP_NOP;
      endcase
   end

endmodule

`default_nettype wire

@@ design/dtte_queue.sv @@
// Short queue of classified items between the front end and the back end.
`default_nettype none

module dtte_queue
   import dtte_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     not_full,
   output logic     not_empty,
   input  logic     pop,
   output item_type head_item
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   item_type          entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   assign not_full  = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_item = entry_ff[rd_ptr_ff];

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

@@ design/dtte_back.sv @@
// Back end: row memory, run state, execution of one item and the response register.
`default_nettype none

module dtte_back
   import dtte_pkg::*;
#(
   parameter int NUM_STATES      = NUM_STATES_DEF,
   parameter int SLOTS_PER_STATE = SLOTS_PER_STATE_DEF
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     q_valid,
   input  item_type q_item,
   output logic     q_pop,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output rsp_type  rsp_data
);

   localparam int IDX_W = $clog2(NUM_STATES);
   localparam int CNT_W = $clog2(SLOTS_PER_STATE + 1);

   // one memory word holds a whole row plus its fill count
   typedef struct packed {
      logic [CNT_W-1:0]                      count;
      logic [SLOTS_PER_STATE-1:0][SYM_W-1:0] sym;
      logic [SLOTS_PER_STATE-1:0][ST_W-1:0]  tgt;
   } row_type;

   row_type         mem [NUM_STATES];

   back_state_type  state_ff, state_in;
   logic [IDX_W-1:0] sweep_ff, sweep_in;
   item_type        cur_ff;
   logic            cur_range_ff;
   logic [IDX_W-1:0] addr_ff;
   row_type         row_ff;
   logic [ST_W-1:0] run_state_ff, run_state_in;
   logic            run_ok_ff, run_ok_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_type         rsp_data_ff, rsp_data_in;

   logic            issue;
   logic            exec;
   logic            sweeping;
   logic [IDX_W-1:0] rd_addr;
   logic            rd_range;
   logic            mem_we;
   logic [IDX_W-1:0] mem_wa;
   row_type         mem_wd;
   row_type         row_new;
   logic            row_we;

   logic [SLOTS_PER_STATE-1:0] match;
   logic [SLOTS_PER_STATE-1:0] hit_oh;
   logic                       hit;
   logic                       seen;
   logic [ST_W-1:0]            hit_tgt;
   logic [SYM_W-1:0]           last_sym;
   logic [ST_W-1:0]            last_tgt;
   logic                       full;

   // next state
   always_comb begin
      state_in = state_ff;
      sweep_in = sweep_ff;
      unique case (state_ff)
         BK_SWEEP: begin
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == IDX_W'(NUM_STATES - 1)) begin
               state_in = BK_IDLE;
               sweep_in = '0;
            end
         end
         BK_IDLE: begin
            if (q_valid && (!rsp_valid_ff || rsp_ready)) begin
               state_in = BK_EXEC;
            end
         end
         BK_EXEC: state_in = BK_IDLE;
         default: state_in = BK_SWEEP;
      endcase
   end

   // state decoded controls
   always_comb begin
      issue    = 1'b0;
      exec     = 1'b0;
      sweeping = 1'b0;
      unique case (state_ff)
         BK_SWEEP: sweeping = 1'b1;
         BK_IDLE:  issue    = q_valid && (!rsp_valid_ff || rsp_ready);
         BK_EXEC:  exec     = 1'b1;
         default:  sweeping = 1'b0;
      endcase
   end

   assign q_pop = issue;

   // read address: feeds use the current run state, others their own row
   always_comb begin
      if (q_item.op == OP_FEED) begin
         rd_addr  = IDX_W'(run_state_ff);
         rd_range = (32'(run_state_ff) < NUM_STATES);
      end else begin
         rd_addr  = IDX_W'(q_item.from_state);
         rd_range = q_item.in_range;
      end
   end

   // slot match over the valid part of the row, first hit wins
   always_comb begin
      seen     = 1'b0;
      hit_tgt  = '0;
      last_sym = '0;
      last_tgt = '0;
      for (int i = 0; i < SLOTS_PER_STATE; i++) begin
         match[i] = cur_range_ff && (CNT_W'(i) < row_ff.count) &&
                    (row_ff.sym[i] == cur_ff.symbol);
         hit_oh[i] = match[i] && !seen;
         seen      = seen || match[i];
         if (hit_oh[i]) begin
            hit_tgt = row_ff.tgt[i];
         end
         if (CNT_W'(i + 1) == row_ff.count) begin
            last_sym = row_ff.sym[i];
            last_tgt = row_ff.tgt[i];
         end
      end
      hit  = seen;
      full = !cur_range_ff || (row_ff.count >= CNT_W'(SLOTS_PER_STATE));
   end

   // execute the item held in the back end
   always_comb begin
      row_new      = row_ff;
      row_we       = 1'b0;
      run_state_in = run_state_ff;
      run_ok_in    = run_ok_ff;
      rsp_data_in  = rsp_data_ff;
      if (exec) begin
         rsp_data_in.status       = STATUS_OK;
         rsp_data_in.target_state = '0;
         unique case (cur_ff.op)
            OP_ADD: begin
               if (full) begin
                  rsp_data_in.status = STATUS_FULL;
               end else if (!hit) begin
                  row_we = 1'b1;
                  for (int i = 0; i < SLOTS_PER_STATE; i++) begin
                     if (CNT_W'(i) == row_ff.count) begin
                        row_new.sym[i] = cur_ff.symbol;
                        row_new.tgt[i] = cur_ff.to_state;
                     end
                  end
                  row_new.count = row_ff.count + 1'b1;
               end
            end
            OP_QUERY: begin
               if (hit) begin
                  rsp_data_in.target_state = hit_tgt;
               end else begin
                  rsp_data_in.status = STATUS_NONE;
               end
            end
            OP_REMOVE: begin
               if (hit) begin
                  row_we = 1'b1;
                  rsp_data_in.target_state = hit_tgt;
                  // last slot fills the gap
                  for (int i = 0; i < SLOTS_PER_STATE; i++) begin
                     if (hit_oh[i]) begin
                        row_new.sym[i] = last_sym;
                        row_new.tgt[i] = last_tgt;
                     end
                  end
                  row_new.count = row_ff.count - 1'b1;
               end else begin
                  rsp_data_in.status = STATUS_NONE;
               end
            end
            OP_START: begin
               run_state_in             = cur_ff.from_state;
               run_ok_in                = 1'b1;
               rsp_data_in.target_state = cur_ff.from_state;
            end
            OP_FEED: begin
               if (run_ok_ff && hit) begin
                  run_state_in             = hit_tgt;
                  rsp_data_in.target_state = hit_tgt;
               end else begin
                  run_ok_in          = 1'b0;
                  rsp_data_in.status = STATUS_NONE;
               end
            end
            default: begin
               rsp_data_in.status = STATUS_OK;
            end
         endcase
         rsp_data_in.run_alive = run_ok_in;
      end
   end

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (exec) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // memory write port: clearing pass after reset, else write-back
   always_comb begin
      if (sweeping) begin
         mem_we = 1'b1;
         mem_wa = sweep_ff;
         mem_wd = '0;
      end else begin
         mem_we = row_we;
         mem_wa = addr_ff;
         mem_wd = row_new;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (issue) begin
         row_ff <= mem[rd_addr];
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_SWEEP;
         sweep_ff     <= '0;
         run_state_ff <= '0;
         run_ok_ff    <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         run_state_ff <= run_state_in;
         run_ok_ff    <= run_ok_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (issue) begin
         cur_ff       <= q_item;
         cur_range_ff <= rd_range;
         addr_ff      <= rd_addr;
      end
   end

endmodule

`default_nettype wire

@@ design/dfa_transition_table_engine_unit.sv @@
// Top level of the transition table engine: front end, item queue and back end.
//
// Programmable automaton: each state owns a row of SLOTS_PER_STATE symbol to
// target transitions. Request items (req_valid/req_ready, req_data) carry an
// action: add, query, remove, start run or feed run symbol. Each item gives
// exactly one response item (rsp_valid/rsp_ready, rsp_data) with a status,
// a target state and the run's alive flag, in request order.
// The front end decodes items into a two-entry queue; the back end reads the
// addressed row from the row memory into the row register, then compares all
// slots in parallel, writes the row back and loads the response register in
// the next cycle. The back end takes a new item only after the last one is
// written back, as read and write-back share the single row memory. An item
// passes through a queue entry, the row register and the response register.
// Reset is synchronous. After reset the back end clears the fill count of
// every row, one row per cycle; items are queued meanwhile (up to the queue
// depth) and run once the pass is done.
// A stalled receiver holds the response; the back end then waits and the
// queue fills, after which req_ready drops.
`default_nettype none

module dfa_transition_table_engine_unit
   import dtte_pkg::*;
#(
   parameter int NUM_STATES      = NUM_STATES_DEF,
   parameter int SLOTS_PER_STATE = SLOTS_PER_STATE_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   item_type front_item;
   item_type head_item;
   logic     q_not_full;
   logic     q_not_empty;
   logic     q_pop;

   assign req_ready = q_not_full;

   dtte_front #(
      .NUM_STATES (NUM_STATES)
   ) u_front (
      .req_data (req_data),
      .item     (front_item)
   );

   dtte_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_valid && q_not_full),
      .push_item (front_item),
      .not_full  (q_not_full),
      .not_empty (q_not_empty),
      .pop       (q_pop),
      .head_item (head_item)
   );

   dtte_back #(
      .NUM_STATES      (NUM_STATES),
      .SLOTS_PER_STATE (SLOTS_PER_STATE)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_not_empty),
      .q_item    (head_item),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

@@ test/tb.sv @@
// Self-checking testbench for the DFA transition table engine unit.

module tb;
   import dtte_pkg::*;

   localparam int NSTATE       = NUM_STATES_DEF;
   localparam int NSLOT        = SLOTS_PER_STATE_DEF;
   localparam int RANDOM_ITEMS = 1200;
   localparam int STALL_LIMIT  = 5000;
   localparam int DRAIN_CYCLES = 20;

   // action codes the block treats as no-ops
   localparam logic [ACT_W-1:0] ACT_UNDEF_LO = 3'd5;
   localparam logic [ACT_W-1:0] ACT_UNDEF_HI = 3'd7;

   typedef struct {
      req_type req;
      bit      typed;
      rsp_type rsp;
   } plan_row_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   dfa_transition_table_engine_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // automaton mirror: slot contents, row fill, current run
   logic [SYM_W-1:0] slot_sym [NSTATE*NSLOT];
   logic [ST_W-1:0]  slot_tgt [NSTATE*NSLOT];
   int               row_fill [NSTATE];
   logic [ST_W-1:0]  run_at;
   logic             run_live;

   rsp_type      pending_rsp[$];
   plan_row_type plan[$];
   bit           item_typed;
   rsp_type      item_rsp;
   bit           quiet_idle;
   int           mismatches;
   int           stall_cycles;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // slot index of sym in row st, or -1; only filled slots are looked at
   function automatic int find_slot_in_row(logic [ST_W-1:0] st, logic [SYM_W-1:0] sym);
      int hit;
      hit = -1;
      for (int i = row_fill[st] - 1; i >= 0; i--)
         if (slot_sym[st*NSLOT + i] == sym) hit = i;
      return hit;
   endfunction

   // applies one item to the mirror and returns the response it should give
   function automatic rsp_type step_automaton(req_type r);
      rsp_type res;
      int      k;
      int      base;
      int      last;
      res.status       = STATUS_OK;
      res.target_state = '0;
      base             = r.from_state * NSLOT;
      case (r.action)
         ACT_ADD: begin
            // full check wins over duplicate check
            if (row_fill[r.from_state] >= NSLOT) begin
               res.status = STATUS_FULL;
            end else if (find_slot_in_row(r.from_state, r.symbol) < 0) begin
               slot_sym[base + row_fill[r.from_state]] = r.symbol;
               slot_tgt[base + row_fill[r.from_state]] = r.to_state;
               row_fill[r.from_state]++;
            end
         end
         ACT_QUERY: begin
            k = find_slot_in_row(r.from_state, r.symbol);
            if (k < 0) res.status = STATUS_NONE;
            else res.target_state = slot_tgt[base + k];
         end
         ACT_REMOVE: begin
            k = find_slot_in_row(r.from_state, r.symbol);
            if (k < 0) begin
               res.status = STATUS_NONE;
            end else begin
               // last slot fills the gap
               last               = row_fill[r.from_state] - 1;
               res.target_state   = slot_tgt[base + k];
               slot_sym[base + k] = slot_sym[base + last];
               slot_tgt[base + k] = slot_tgt[base + last];
               row_fill[r.from_state] = last;
            end
         end
         ACT_START: begin
            run_at           = r.from_state;
            run_live         = 1'b1;
            res.target_state = r.from_state;
         end
         ACT_FEED: begin
            k = run_live ? find_slot_in_row(run_at, r.symbol) : -1;
            if (k < 0) begin
               run_live   = 1'b0;
               res.status = STATUS_NONE;
            end else begin
               run_at           = slot_tgt[run_at*NSLOT + k];
               res.target_state = run_at;
            end
         end
         default: ;
      endcase
      res.run_alive = run_live;
      return res;
   endfunction

   function automatic plan_row_type plan_row(logic [ACT_W-1:0] act, int from, int sym, int to,
                                             bit typed, logic [STS_W-1:0] sts, int tgt,
                                             bit alive);
      plan_row_type p;
      p.req.action           = act;
      p.req.from_state       = ST_W'(from);
      p.req.symbol           = SYM_W'(sym);
      p.req.to_state         = ST_W'(to);
      p.typed                = typed;
      p.rsp.status           = sts;
      p.rsp.target_state     = ST_W'(tgt);
      p.rsp.run_alive        = alive;
      return p;
   endfunction

   // mostly a handful of states so rows fill and runs go deep
   function automatic logic [ST_W-1:0] pick_state();
      return ($urandom_range(0, 99) < 85) ? ST_W'($urandom_range(0, 7))
                                          : ST_W'($urandom_range(0, 63));
   endfunction

   // mostly a six-symbol alphabet so lookups hit
   function automatic logic [SYM_W-1:0] pick_symbol();
      return ($urandom_range(0, 99) < 85) ? SYM_W'($urandom_range(0, 5) * 51)
                                          : SYM_W'($urandom_range(0, 255));
   endfunction

   function automatic req_type random_item();
      req_type r;
      int      pick;
      pick         = $urandom_range(0, 99);
      r.from_state = pick_state();
      r.symbol     = pick_symbol();
      r.to_state   = pick_state();
      if (pick < 25) r.action = ACT_ADD;
      else if (pick < 45) r.action = ACT_QUERY;
      else if (pick < 55) r.action = ACT_REMOVE;
      else if (pick < 62) r.action = ACT_START;
      else if (pick < 92) r.action = ACT_FEED;
      else r = $bits(req_type)'($urandom);
      return r;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
      mismatches++;
   endtask

   // drive one item at the falling edge, hold until accepted
   task automatic send_item(req_type item, bit typed, rsp_type typed_rsp);
      while (!quiet_idle && $urandom_range(0, 99) < 29) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      item_typed = typed;
      item_rsp   = typed_rsp;
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_ready !== 1'b1);
      @(negedge clock);
   endtask

   // response side back-pressure
   always @(negedge clock) rsp_ready <= quiet_idle || ($urandom_range(0, 99) >= 29);

   // accept, predict and check at the rising edge
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (req_valid && req_ready === 1'b1) begin
            want = step_automaton(req_data);
            pending_rsp.push_back(item_typed ? item_rsp : want);
         end
         if (rsp_valid === 1'b1 && rsp_ready) begin
            if (pending_rsp.size() == 0) begin
               report_mismatch("response item with nothing pending", 1, 0);
            end else begin
               want = pending_rsp.pop_front();
               if (rsp_data.status !== want.status)
                  report_mismatch("status", rsp_data.status, want.status);
               if (rsp_data.target_state !== want.target_state)
                  report_mismatch("target_state", rsp_data.target_state, want.target_state);
               if (rsp_data.run_alive !== want.run_alive)
                  report_mismatch("run_alive", rsp_data.run_alive, want.run_alive);
            end
         end
         stall_cycles <= ((req_valid && req_ready === 1'b1) || (rsp_valid === 1'b1 && rsp_ready))
                         ? 0 : stall_cycles + 1;
      end
   end

   // watchdog: no handshake for too long
   initial begin
      do @(posedge clock); while (stall_cycles < STALL_LIMIT);
      $display("[%0t] no item moved for %0d cycles", $time, STALL_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_data     = '0;
      rsp_ready    = 1'b0;
      quiet_idle   = 1'b0;
      mismatches   = 0;
      stall_cycles = 0;
      item_typed   = 1'b0;
      item_rsp     = '0;
      foreach (row_fill[i]) row_fill[i] = 0;
      run_at   = '0;
      run_live = 1'b1;

      // empty table, failed run before any start
      plan.push_back(plan_row(ACT_QUERY,  0, 8'h00,  0, 1, STATUS_NONE, 0, 1));
      plan.push_back(plan_row(ACT_FEED,   0, 8'h00,  0, 1, STATUS_NONE, 0, 0));
      plan.push_back(plan_row(ACT_START,  0, 8'h00,  0, 1, STATUS_OK,   0, 1));
      // fill row 0, then hit the full row with a new and a duplicate symbol
      plan.push_back(plan_row(ACT_ADD,    0, 8'h00, 63, 1, STATUS_OK,   0, 1));
      plan.push_back(plan_row(ACT_ADD,    0, 8'hFF,  0, 1, STATUS_OK,   0, 1));
      plan.push_back(plan_row(ACT_ADD,    0, 8'h55, 42, 1, STATUS_OK,   0, 1));
      plan.push_back(plan_row(ACT_ADD,    0, 8'hAA, 21, 1, STATUS_OK,   0, 1));
      plan.push_back(plan_row(ACT_ADD,    0, 8'h11,  5, 1, STATUS_FULL, 0, 1));
      plan.push_back(plan_row(ACT_ADD,    0, 8'hFF,  9, 1, STATUS_FULL, 0, 1));
      plan.push_back(plan_row(ACT_QUERY,  0, 8'hFF,  0, 1, STATUS_OK,   0, 1));
      plan.push_back(plan_row(ACT_QUERY,  0, 8'h00,  0, 1, STATUS_OK,  63, 1));
      // remove the first slot, then check the moved slot
      plan.push_back(plan_row(ACT_REMOVE, 0, 8'h00,  0, 1, STATUS_OK,  63, 1));
      plan.push_back(plan_row(ACT_ADD,    0, 8'h55,  7, 1, STATUS_OK,   0, 1));
      plan.push_back(plan_row(ACT_QUERY,  0, 8'hAA,  0, 1, STATUS_OK,  21, 1));
      plan.push_back(plan_row(ACT_REMOVE, 0, 8'h00,  0, 1, STATUS_NONE, 0, 1));
      // remove the last slot of the row
      plan.push_back(plan_row(ACT_REMOVE, 0, 8'h55,  0, 1, STATUS_OK,  42, 1));
      plan.push_back(plan_row(ACT_ADD,    0, 8'h55, 42, 1, STATUS_OK,   0, 1));
      plan.push_back(plan_row(ACT_ADD,   63, 8'h80,  0, 1, STATUS_OK,   0, 1));
      plan.push_back(plan_row(ACT_ADD,   42, 8'h01, 63, 1, STATUS_OK,   0, 1));
      // a run through 0 -> 42 -> 63 -> 0, then a miss and a feed on a dead run
      plan.push_back(plan_row(ACT_START,  0, 8'h00,  0, 1, STATUS_OK,   0, 1));
      plan.push_back(plan_row(ACT_FEED,   0, 8'h55,  0, 0, STATUS_OK,   0, 0));
      plan.push_back(plan_row(ACT_FEED,   0, 8'h01,  0, 0, STATUS_OK,   0, 0));
      plan.push_back(plan_row(ACT_FEED,   0, 8'h80,  0, 0, STATUS_OK,   0, 0));
      plan.push_back(plan_row(ACT_FEED,   0, 8'h12,  0, 1, STATUS_NONE, 0, 0));
      plan.push_back(plan_row(ACT_FEED,   0, 8'hFF,  0, 1, STATUS_NONE, 0, 0));
      // undefined actions leave everything alone
      plan.push_back(plan_row(ACT_UNDEF_LO, 0, 8'h00, 0, 1, STATUS_OK,  0, 0));
      plan.push_back(plan_row(ACT_UNDEF_HI, 63, 8'hFF, 63, 1, STATUS_OK, 0, 0));

      // reset, released at a falling edge
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (plan[i]) send_item(plan[i].req, plan[i].typed, plan[i].rsp);

      // random traffic with a back-to-back stretch in the middle
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         quiet_idle = (n >= 500 && n < 700);
         send_item(random_item(), 1'b0, '0);
      end
      quiet_idle = 1'b0;
      req_valid <= 1'b0;

      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
